>>> rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int MaxPointsDef = 16;
  localparam int IndexW       = 4;
  localparam int DateW        = 24;
  localparam int RateW        = 32;
  localparam int CountW       = 5;
  localparam int RegionW      = 2;
  localparam int InDataW      = 64;
  localparam int OutDataW     = 32;
  localparam int QuoW         = RateW;
  localparam int MagW         = RateW + DateW;
  localparam int ProdW        = RateW + DateW + 2;
  localparam int DivCntW      = $clog2(QuoW);

  localparam logic [CountW-1:0] CountReset = CountW'(2);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [RegionW-1:0] {
    REGION_LEFT   = 2'd0,
    REGION_INSIDE = 2'd1,
    REGION_RIGHT  = 2'd2
  } region_e;

  typedef enum logic [1:0] {
    RD_FIRST = 2'd0,
    RD_LAST  = 2'd1,
    RD_NEXT  = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_RDATA  = 2'd0,
    RES_PREV   = 2'd1,
    RES_LAST   = 2'd2,
    RES_INTERP = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic     query_start;
    logic     load_wr;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     cnt_inc;
    logic     save_prev;
    logic     save_last;
    logic     mul_load;
    logic     prod_load;
    logic     div_init;
    logic     div_step;
    logic     res_load;
    res_sel_e res_sel;
    region_e  res_region;
    logic     out_push;
  } pli_cmd_t;

  typedef struct packed {
    logic le_first;
    logic ge_last;
    logic in_seg;
    logic zero_width;
    logic at_last;
    logic div_last;
    logic out_free;
  } pli_status_t;

endpackage

`default_nettype wire

>>> rtl/core/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer: table read order, segment scan, multiply and divide steps
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ctrl
  import pli_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire op_e         in_op_i,
  output logic             in_ready_o,
  input  wire pli_status_t status_i,
  output pli_cmd_t         cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FIRST = 9'b000000010,
    S_LAST  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_DINIT = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            cmd_o.query_start = 1'b1;
            cmd_o.rd_en       = 1'b1;
            cmd_o.rd_sel      = RD_FIRST;
            state_d           = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (status_i.le_first) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_sel    = RES_RDATA;
          cmd_o.res_region = REGION_LEFT;
          state_d          = S_OUT;
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = RD_LAST;
          state_d         = S_LAST;
        end
      end
      S_LAST: begin
        if (status_i.ge_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_sel    = RES_RDATA;
          cmd_o.res_region = REGION_RIGHT;
          state_d          = S_OUT;
        end else begin
          cmd_o.save_last = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = RD_NEXT;
          cmd_o.cnt_inc   = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.in_seg) begin
          if (status_i.zero_width) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_sel    = RES_PREV;
            cmd_o.res_region = REGION_INSIDE;
            state_d          = S_OUT;
          end else begin
            cmd_o.mul_load = 1'b1;
            state_d        = S_MUL;
          end
        end else if (status_i.at_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_sel    = RES_LAST;
          cmd_o.res_region = REGION_RIGHT;
          state_d          = S_OUT;
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = RD_NEXT;
          cmd_o.cnt_inc   = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.prod_load = 1'b1;
        state_d         = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_sel    = RES_INTERP;
        cmd_o.res_region = REGION_INSIDE;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_push = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pli_dp.sv
// ----------------------------------------------------------------------------
// pli_dp
// Datapath: breakpoint memories, compares, multiplier, radix-2 divider
// ----------------------------------------------------------------------------
`default_nettype none

module pli_dp
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire pli_cmd_t                 cmd_i,
  output pli_status_t                   status_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CountW-1:0]        cfg_data_i,
  input  wire logic [IndexW-1:0]        in_index_i,
  input  wire logic [DateW-1:0]         in_date_i,
  input  wire logic signed [RateW-1:0]  in_rate_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [RateW-1:0]       out_rate_o,
  output region_e                       out_region_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = (CountW > AW + 1) ? CountW : AW + 1;

  logic [DateW-1:0] date_mem [MAX_POINTS];
  logic [RateW-1:0] rate_mem [MAX_POINTS];

  logic [CountW-1:0]       count_q;
  logic [NW-1:0]           count_ext;
  logic [NW-1:0]           n_eff;
  logic [AW-1:0]           last_idx;
  logic [AW-1:0]           cnt_q;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [DateW-1:0]        date_q;
  logic [DateW-1:0]        rd_date_q;
  logic [RateW-1:0]        rd_rate_q;
  logic [DateW-1:0]        prev_date_q;
  logic [RateW-1:0]        prev_rate_q;
  logic [RateW-1:0]        last_rate_q;
  logic signed [RateW:0]   diff_q;
  logic [DateW-1:0]        off_q;
  logic [DateW-1:0]        span_q;
  logic signed [ProdW-1:0] prod_q;
  logic [ProdW-1:0]        mag;
  logic                    neg_q;
  logic [DateW-1:0]        rem_q;
  logic [QuoW-1:0]         quo_q;
  logic [DivCntW-1:0]      div_cnt_q;
  logic [DateW:0]          shifted;
  logic [DateW+1:0]        trial;
  logic                    fits;
  logic [RateW-1:0]        interp;
  logic [RateW-1:0]        res_rate;
  logic                    out_valid_q;
  logic [RateW-1:0]        out_rate_q;
  region_e                 out_region_q;

  // point count, zero read as one, saturated at the table depth
  assign count_ext = NW'(count_q);
  assign n_eff     = (count_q == '0) ? NW'(1) :
                     (count_ext > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : count_ext;
  assign last_idx  = AW'(n_eff - NW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign wr_en = cmd_i.load_wr && (32'(in_index_i) < 32'(MAX_POINTS));

  always_comb begin
    case (cmd_i.rd_sel)
      RD_FIRST: rd_addr = '0;
      RD_LAST:  rd_addr = last_idx;
      RD_NEXT:  rd_addr = cnt_q + AW'(1);
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      date_mem[AW'(in_index_i)] <= in_date_i;
      rate_mem[AW'(in_index_i)] <= in_rate_i;
    end
    if (cmd_i.rd_en) begin
      rd_date_q <= date_mem[rd_addr];
      rd_rate_q <= rate_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.query_start) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
    end
  end

  // divider step: remainder stays below the span
  assign mag     = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
  assign shifted = {rem_q, quo_q[QuoW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, span_q};
  assign fits    = !trial[DateW+1];
  assign interp  = prev_rate_q + (neg_q ? (~quo_q + RateW'(1)) : quo_q);

  always_comb begin
    case (cmd_i.res_sel)
      RES_RDATA:  res_rate = rd_rate_q;
      RES_PREV:   res_rate = prev_rate_q;
      RES_LAST:   res_rate = last_rate_q;
      RES_INTERP: res_rate = interp;
      default:    res_rate = rd_rate_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      date_q <= in_date_i;
    end
    if (cmd_i.save_prev) begin
      prev_date_q <= rd_date_q;
      prev_rate_q <= rd_rate_q;
    end
    if (cmd_i.save_last) begin
      last_rate_q <= rd_rate_q;
    end
    if (cmd_i.mul_load) begin
      diff_q <= $signed({rd_rate_q[RateW-1], rd_rate_q})
              - $signed({prev_rate_q[RateW-1], prev_rate_q});
      off_q  <= date_q - prev_date_q;
      span_q <= rd_date_q - prev_date_q;
    end
    if (cmd_i.prod_load) begin
      prod_q <= diff_q * $signed({1'b0, off_q});
    end
    if (cmd_i.div_init) begin
      neg_q <= prod_q[ProdW-1];
      rem_q <= mag[MagW-1:QuoW];
      quo_q <= mag[QuoW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? trial[DateW-1:0] : shifted[DateW-1:0];
      quo_q <= {quo_q[QuoW-2:0], fits};
    end
    if (cmd_i.res_load) begin
      out_rate_q   <= res_rate;
      out_region_q <= cmd_i.res_region;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [RateW-1:0] res_hold_q;
  region_e          res_region_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_push) begin
      res_hold_q   <= out_rate_q;
      res_region_q <= out_region_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_rate_o   = res_hold_q;
  assign out_region_o = res_region_q;

  assign status_o.le_first   = (date_q <= rd_date_q);
  assign status_o.ge_last    = (date_q >= rd_date_q);
  assign status_o.in_seg     = (date_q >= prev_date_q) && (date_q <= rd_date_q);
  assign status_o.zero_width = (rd_date_q == prev_date_q);
  assign status_o.at_last    = (cnt_q == last_idx);
  assign status_o.div_last   = (div_cnt_q == '1);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < span_q))
    else $error("divider remainder not below span");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_en && cmd_i.rd_sel == RD_NEXT) |-> (cnt_q < last_idx))
    else $error("segment scan read past last valid entry");

  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_load |-> (rd_date_q != prev_date_q))
    else $error("interpolation started on zero-width segment");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_push |-> (!out_valid_q || out_ready_i))
    else $error("result pushed over an item not yet taken");

endmodule

`default_nettype wire

>>> rtl/core/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with linear interpolation and flat extrapolation
// ----------------------------------------------------------------------------
//  channel   dir  accepted when               payload
//  s_axis    in   s_axis_tvalid & tready      tuser: operation; tdata: index, date, rate
//  m_axis    out  m_axis_tvalid & tready      tuser: region; tdata: rate_out
//  cfg       in   cfg_valid_i & cfg_ready_o   cfg_data_i: point_count
//
//  load: taken while idle, loads may follow back to back
//  query: flat left of the first point, flat right of the last, else
//  interpolated, using the one-entry-a-cycle segment scan and the
//  32-step radix-2 divider
//  a finished result sits in the output register; the next item is taken
//  while it waits, a second result waits for it to leave
//  reset: point count 2, no item pending; table contents undefined until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // point_index, date_value, point_rate
  input  wire logic                s_axis_tuser,   // operation
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // rate_out
  output logic [RegionW-1:0]       m_axis_tuser,   // region
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CountW-1:0]   cfg_data_i
);

  pli_cmd_t          cmd;
  pli_status_t       status;
  logic              in_ready;
  logic signed [RateW-1:0] out_rate;
  region_e           out_region;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;

  pli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (op_e'(s_axis_tuser)),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pli_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_index_i   (s_axis_tdata[IndexW-1:0]),
    .in_date_i    (s_axis_tdata[IndexW+DateW-1:IndexW]),
    .in_rate_i    (s_axis_tdata[IndexW+DateW+RateW-1:IndexW+DateW]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rate_o   (out_rate),
    .out_region_o (out_region)
  );

  assign m_axis_tdata = out_rate;
  assign m_axis_tuser = out_region;

endmodule

`default_nettype wire
